// ----- design/bmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp_pkg: shared types and constants of the block max pooling unit
// Widths, register indexes, reset values and the per-pixel position record
// passed from the position tracker to the update stage.
// ----------------------------------------------------------------------------
`default_nettype none

package bmp_pkg;

  // Frame and tile limits
  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned ROWS_LIMIT = 2048;
  localparam int unsigned MAX_TILE   = 16;

  // Field and counter widths
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(ROWS_LIMIT);
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned TILE_W     = $clog2(MAX_TILE) + 1;
  localparam int unsigned IN_TILE_W  = $clog2(MAX_TILE);
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 2'd3;

  // Register reset values
  localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 12'd480;
  localparam logic [TILE_W-1:0] RST_BLOCK_WIDTH  = 5'd8;
  localparam logic [TILE_W-1:0] RST_BLOCK_HEIGHT = 5'd8;

  // Position record of one pixel
  typedef struct packed {
    logic [COL_W-1:0] tile_col;
    logic [ROW_W-1:0] tile_row;
    logic [PIX_W-1:0] pixel;
    logic             first;       // first pixel of its tile
    logic             tile_end;    // last pixel of its tile
    logic             complete;    // tile lies fully inside the frame
    logic             frame_last;  // last complete tile of the frame
  } pix_info_t;

endpackage

`default_nettype wire

// ----- design/block_max_pooling.sv -----
// Result path: the tile's last pixel is registered in the merge stage, then in the result register.
// Throughput: one pixel per cycle, set by the running-maxima RAM (one read, one
//   write per cycle) with a one-entry bypass for back-to-back hits on a column.
//   The input stalls only while a finished tile waits behind a held result.
// Reset: counters clear, registers take 640 x 480 frame and 8 x 8 tiles; the
//   maxima RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// block_max_pooling: non-overlapping 2-D max pooling over a raster stream
// Tracks the raster position, keeps one running maximum per tile column in a
// RAM and emits the maximum of each complete tile.
// ----------------------------------------------------------------------------
`default_nettype none

module block_max_pooling (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_write_i,
  input  wire logic [bmp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [bmp_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [bmp_pkg::COL_W-1:0]       tile_column_o,
  output logic      [bmp_pkg::ROW_W-1:0]       tile_row_o,
  output logic      [bmp_pkg::PIX_W-1:0]       tile_maximum_o,
  output logic                                 frame_done_o
);

  import bmp_pkg::*;

  pix_info_t        info;
  logic             in_fire;
  logic [PIX_W-1:0] rd_data;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [PIX_W-1:0] wr_data;

  // Transfer on the input channel
  assign in_fire = in_valid_i && in_ready_o;

  // Position tracker and registers
  bmp_pos u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_write_i   (cfg_write_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_fire_i     (in_fire),
    .pixel_value_i (pixel_value_i),
    .info_o        (info)
  );

  // Running maxima, one entry per tile column
  bmp_ram #(
    .ADDR_W (COL_W),
    .DATA_W (PIX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (in_fire),
    .rd_addr_i (info.tile_col),
    .rd_data_o (rd_data)
  );

  // Read-modify-write and result register
  bmp_update u_update (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .info_i         (info),
    .in_ready_o     (in_ready_o),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tile_column_o  (tile_column_o),
    .tile_row_o     (tile_row_o),
    .tile_maximum_o (tile_maximum_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

`default_nettype wire

// ----- design/bmp_ram.sv -----
// ----------------------------------------------------------------------------
// bmp_ram: single-port-write, single-port-read synchronous RAM
// One write and one read per cycle, read data registered, read-before-write.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_ram #(
  parameter int unsigned ADDR_W = 11,
  parameter int unsigned DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/bmp_pos.sv -----
// ----------------------------------------------------------------------------
// bmp_pos: configuration registers and raster position tracker
// Holds the clamped frame and tile sizes, counts pixel and tile positions and
// classifies each incoming pixel against its tile.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pos (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_write_i,
  input  wire logic [bmp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_fire_i,
  input  wire logic [bmp_pkg::PIX_W-1:0]       pixel_value_i,
  output bmp_pkg::pix_info_t                   info_o
);

  import bmp_pkg::*;

  localparam int unsigned SUM_W = DIM_W + 1;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
    logic [TILE_W-1:0] r;
    if (v == '0) begin
      r = TILE_W'(1);
    end else if (v > TILE_W'(MAX_TILE)) begin
      r = TILE_W'(MAX_TILE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [DIM_W-1:0]     width_q, height_q;
  logic [TILE_W-1:0]    bw_q, bh_q;
  logic [COL_W-1:0]     pix_col_q, pix_col_d;
  logic [ROW_W-1:0]     pix_row_q, pix_row_d;
  logic [IN_TILE_W-1:0] cit_q, cit_d, rit_q, rit_d;
  logic [COL_W-1:0]     tci_q, tci_d;
  logic [ROW_W-1:0]     tri_q, tri_d;

  logic [SUM_W-1:0]  col_start, col_end, row_start, row_end;
  logic [DIM_W-1:0]  col_inc, row_inc;
  logic [TILE_W-1:0] cit_inc, rit_inc;
  logic              complete_x, complete_y, last_x, last_y;

  // Classify the current pixel against its tile
  assign col_start  = SUM_W'(pix_col_q) - SUM_W'(cit_q);
  assign row_start  = SUM_W'(pix_row_q) - SUM_W'(rit_q);
  assign col_end    = col_start + SUM_W'(bw_q);
  assign row_end    = row_start + SUM_W'(bh_q);
  assign complete_x = col_end <= SUM_W'(width_q);
  assign complete_y = row_end <= SUM_W'(height_q);
  assign last_x     = (col_end + SUM_W'(bw_q)) > SUM_W'(width_q);
  assign last_y     = (row_end + SUM_W'(bh_q)) > SUM_W'(height_q);

  assign info_o.tile_col   = tci_q;
  assign info_o.tile_row   = tri_q;
  assign info_o.pixel      = pixel_value_i;
  assign info_o.first      = (cit_q == '0) && (rit_q == '0);
  assign info_o.tile_end   = (TILE_W'(cit_q) == bw_q - TILE_W'(1)) &&
                             (TILE_W'(rit_q) == bh_q - TILE_W'(1));
  assign info_o.complete   = complete_x && complete_y;
  assign info_o.frame_last = last_x && last_y;

  // Advance the raster position on each transfer
  assign col_inc = DIM_W'(pix_col_q) + DIM_W'(1);
  assign row_inc = DIM_W'(pix_row_q) + DIM_W'(1);
  assign cit_inc = TILE_W'(cit_q) + TILE_W'(1);
  assign rit_inc = TILE_W'(rit_q) + TILE_W'(1);

  always_comb begin
    pix_col_d = pix_col_q;
    pix_row_d = pix_row_q;
    cit_d     = cit_q;
    rit_d     = rit_q;
    tci_d     = tci_q;
    tri_d     = tri_q;
    if (in_fire_i) begin
      pix_col_d = col_inc[COL_W-1:0];
      if (cit_inc >= bw_q) begin
        cit_d = '0;
        tci_d = tci_q + COL_W'(1);
      end else begin
        cit_d = cit_inc[IN_TILE_W-1:0];
      end
      if (col_inc >= width_q) begin
        pix_col_d = '0;
        cit_d     = '0;
        tci_d     = '0;
        pix_row_d = row_inc[ROW_W-1:0];
        if (rit_inc >= bh_q) begin
          rit_d = '0;
          tri_d = tri_q + ROW_W'(1);
        end else begin
          rit_d = rit_inc[IN_TILE_W-1:0];
        end
        if (row_inc >= height_q) begin
          pix_row_d = '0;
          rit_d     = '0;
          tri_d     = '0;
        end
      end
    end
  end

  // Registers and counters; a register write restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= RST_FRAME_WIDTH;
      height_q  <= RST_FRAME_HEIGHT;
      bw_q      <= RST_BLOCK_WIDTH;
      bh_q      <= RST_BLOCK_HEIGHT;
      pix_col_q <= '0;
      pix_row_q <= '0;
      cit_q     <= '0;
      rit_q     <= '0;
      tci_q     <= '0;
      tri_q     <= '0;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          width_q <= clamp_dim(cfg_data_i, DIM_W'(MAX_WIDTH));
        end
        REG_FRAME_HEIGHT: begin
          height_q <= clamp_dim(cfg_data_i, DIM_W'(ROWS_LIMIT));
        end
        REG_BLOCK_WIDTH: begin
          bw_q <= clamp_tile(cfg_data_i[TILE_W-1:0]);
        end
        REG_BLOCK_HEIGHT: begin
          bh_q <= clamp_tile(cfg_data_i[TILE_W-1:0]);
        end
        default: begin
        end
      endcase
      pix_col_q <= '0;
      pix_row_q <= '0;
      cit_q     <= '0;
      rit_q     <= '0;
      tci_q     <= '0;
      tri_q     <= '0;
    end else begin
      pix_col_q <= pix_col_d;
      pix_row_q <= pix_row_d;
      cit_q     <= cit_d;
      rit_q     <= rit_d;
      tci_q     <= tci_d;
      tri_q     <= tri_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/bmp_update.sv -----
// ----------------------------------------------------------------------------
// bmp_update: read-modify-write stage and result register
// Merges each pixel into the running maximum of its tile column, forwards a
// write that lands in the same cycle as the read, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_update (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire bmp_pkg::pix_info_t          info_i,
  output logic                             in_ready_o,
  input  wire logic [bmp_pkg::PIX_W-1:0]   rd_data_i,
  output logic                             wr_en_o,
  output logic      [bmp_pkg::COL_W-1:0]   wr_addr_o,
  output logic      [bmp_pkg::PIX_W-1:0]   wr_data_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [bmp_pkg::COL_W-1:0]   tile_column_o,
  output logic      [bmp_pkg::ROW_W-1:0]   tile_row_o,
  output logic      [bmp_pkg::PIX_W-1:0]   tile_maximum_o,
  output logic                             frame_done_o
);

  import bmp_pkg::*;

  logic             s1_valid_q;
  pix_info_t        s1_info_q;
  logic             fwd_hit_q;
  logic [PIX_W-1:0] fwd_data_q;
  logic             out_valid_q;

  logic             in_fire, s1_result, out_free, s1_advance, out_load;
  logic [PIX_W-1:0] base, merged;

  // Handshake between stage and result register
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_result  = s1_info_q.complete && s1_info_q.tile_end;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && (!s1_result || out_free);
  assign out_load   = s1_advance && s1_result;
  assign in_ready_o = !s1_valid_q || s1_advance;

  // Merge the pixel into the running maximum
  assign base   = fwd_hit_q ? fwd_data_q : rd_data_i;
  assign merged = (s1_info_q.first || (s1_info_q.pixel > base)) ?
                  s1_info_q.pixel : base;

  assign wr_en_o   = s1_advance && s1_info_q.complete;
  assign wr_addr_o = s1_info_q.tile_col;
  assign wr_data_o = merged;

  // Stage and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= wr_en_o && (wr_addr_o == info_i.tile_col);
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_info_q  <= info_i;
      fwd_data_q <= wr_data_o;
    end
    if (out_load) begin
      tile_column_o  <= s1_info_q.tile_col;
      tile_row_o     <= s1_info_q.tile_row;
      tile_maximum_o <= merged;
      frame_done_o   <= s1_info_q.frame_last;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_merge_not_below_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> wr_data_o >= s1_info_q.pixel)
    else $error("stored maximum below the merged pixel");

  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_result && out_valid_q && !out_ready_i)
    else $error("input stalled without a waiting result");

  a_result_carries_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && (tile_maximum_o == $past(merged)))
    else $error("result register lost the tile maximum");
`endif

endmodule

`default_nettype wire

// ----- bench/bmp_checker.sv -----
// ----------------------------------------------------------------------------
// bmp_checker: result checker for the block max pooling unit
// Watches register writes and pixel transfers, tracks the raster and tile
// position, predicts each completed tile and compares it with the result
// transfers in order.
// ----------------------------------------------------------------------------

module bmp_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_write_i,
  input  wire logic [bmp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_ready_i,
  input  wire logic [bmp_pkg::PIX_W-1:0]       pixel_value_i,
  input  wire logic                            out_valid_i,
  input  wire logic                            out_ready_i,
  input  wire logic [bmp_pkg::COL_W-1:0]       tile_column_i,
  input  wire logic [bmp_pkg::ROW_W-1:0]       tile_row_i,
  input  wire logic [bmp_pkg::PIX_W-1:0]       tile_maximum_i,
  input  wire logic                            frame_done_i,
  output int                                   mismatch_count_o,
  output int                                   pending_o
);

  import bmp_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] maximum;
    logic             done;
  } tile_result_t;

  // Register copies, as written
  logic [DIM_W-1:0]  frame_w_q;
  logic [DIM_W-1:0]  frame_h_q;
  logic [TILE_W-1:0] block_w_q;
  logic [TILE_W-1:0] block_h_q;

  // Raster and tile position
  int unsigned pix_col, pix_row, col_in_tile, row_in_tile, tile_col_idx, tile_row_idx;

  logic [PIX_W-1:0] column_max [MAX_WIDTH];
  tile_result_t     expected_tiles [$];
  tile_result_t     got, want;
  int               fail_count;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function void restart_frame();
    pix_col      = 0;
    pix_row      = 0;
    col_in_tile  = 0;
    row_in_tile  = 0;
    tile_col_idx = 0;
    tile_row_idx = 0;
  endfunction

  // Fold one pixel into its tile column and queue the tile when it closes
  function void pool_pixel(input logic [PIX_W-1:0] px);
    int unsigned  w, h, bw, bh, tiles_x, tiles_y;
    logic [PIX_W-1:0] m;
    tile_result_t t;
    w       = clamp_dim(frame_w_q, MAX_WIDTH);
    h       = clamp_dim(frame_h_q, ROWS_LIMIT);
    bw      = clamp_dim(block_w_q, MAX_TILE);
    bh      = clamp_dim(block_h_q, MAX_TILE);
    tiles_x = w / bw;
    tiles_y = h / bh;

    // Only tiles fully inside the frame take part
    if (tile_col_idx < tiles_x && tile_row_idx < tiles_y) begin
      if (col_in_tile == 0 && row_in_tile == 0) begin
        m = px;
      end else begin
        m = column_max[tile_col_idx];
        if (px > m) m = px;
      end
      column_max[tile_col_idx] = m;
      if (col_in_tile == bw - 1 && row_in_tile == bh - 1) begin
        t.col     = tile_col_idx[COL_W-1:0];
        t.row     = tile_row_idx[ROW_W-1:0];
        t.maximum = m;
        t.done    = (tile_col_idx == tiles_x - 1) && (tile_row_idx == tiles_y - 1);
        expected_tiles.push_back(t);
      end
    end

    // Advance the position, wrapping at row and frame ends
    pix_col++;
    col_in_tile++;
    if (col_in_tile >= bw) begin
      col_in_tile = 0;
      tile_col_idx++;
    end
    if (pix_col >= w) begin
      pix_col      = 0;
      col_in_tile  = 0;
      tile_col_idx = 0;
      pix_row++;
      row_in_tile++;
      if (row_in_tile >= bh) begin
        row_in_tile = 0;
        tile_row_idx++;
      end
      if (pix_row >= h) begin
        pix_row      = 0;
        row_in_tile  = 0;
        tile_row_idx = 0;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_w_q = RST_FRAME_WIDTH;
      frame_h_q = RST_FRAME_HEIGHT;
      block_w_q = RST_BLOCK_WIDTH;
      block_h_q = RST_BLOCK_HEIGHT;
      restart_frame();
      expected_tiles.delete();
    end else begin
      // Compare each result transfer with the oldest expected tile
      if (out_valid_i && out_ready_i) begin
        got.col     = tile_column_i;
        got.row     = tile_row_i;
        got.maximum = tile_maximum_i;
        got.done    = frame_done_i;
        if (expected_tiles.size() == 0) begin
          $display("%0t: unexpected tile: expected none, actual col %0d row %0d max %0d done %0b",
                   $time, got.col, got.row, got.maximum, got.done);
          fail_count++;
        end else begin
          want = expected_tiles.pop_front();
          if (got !== want) begin
            $display("%0t: tile differs: expected col %0d row %0d max %0d done %0b,",
                     $time, want.col, want.row, want.maximum, want.done);
            $display("%0t:   actual col %0d row %0d max %0d done %0b",
                     $time, got.col, got.row, got.maximum, got.done);
            fail_count++;
          end
        end
      end

      // Track register writes; each one restarts the frame
      if (cfg_write_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  frame_w_q = cfg_data_i;
          REG_FRAME_HEIGHT: frame_h_q = cfg_data_i;
          REG_BLOCK_WIDTH:  block_w_q = cfg_data_i[TILE_W-1:0];
          REG_BLOCK_HEIGHT: block_h_q = cfg_data_i[TILE_W-1:0];
          default: ;
        endcase
        restart_frame();
      end

      if (in_valid_i && in_ready_i) begin
        pool_pixel(pixel_value_i);
      end
    end
    mismatch_count_o <= fail_count;
    pending_o        <= expected_tiles.size();
  end

endmodule

// ----- bench/block_max_pooling_tb.sv -----
// ----------------------------------------------------------------------------
// block_max_pooling_tb: testbench of the block max pooling unit
// Streams pixels through frames of many shapes and tile sizes, from one-pixel
// tiles up to the widest and tallest frames, with bursty input and a stalling
// output; the checker predicts every tile and compares it in order.
// ----------------------------------------------------------------------------

module block_max_pooling_tb;

  import bmp_pkg::*;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_write_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic [PIX_W-1:0]      pixel_value_i = '0;
  logic                  out_ready_i   = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [COL_W-1:0]      tile_column_o;
  logic [ROW_W-1:0]      tile_row_o;
  logic [PIX_W-1:0]      tile_maximum_o;
  logic                  frame_done_o;

  int mismatches;
  int tiles_pending;
  int burst_left = 0;
  int ready_run  = 0;
  int stall_run  = 0;

  // Frame of 5 x 3 with 2 x 2 tiles: right column and bottom row stay partial
  logic [PIX_W-1:0] partial_frame_px [15] = '{
    8'd255, 8'd0,   8'd17, 8'd3,   8'd200,
    8'd0,   8'd254, 8'd99, 8'd255, 8'd9,
    8'd1,   8'd2,   8'd3,  8'd4,   8'd5
  };

  block_max_pooling u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_write_i    (cfg_write_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_value_i  (pixel_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tile_column_o  (tile_column_o),
    .tile_row_o     (tile_row_o),
    .tile_maximum_o (tile_maximum_o),
    .frame_done_o   (frame_done_o)
  );

  bmp_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_write_i      (cfg_write_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .pixel_value_i    (pixel_value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tile_column_i    (tile_column_o),
    .tile_row_i       (tile_row_o),
    .tile_maximum_i   (tile_maximum_o),
    .frame_done_i     (frame_done_o),
    .mismatch_count_o (mismatches),
    .pending_o        (tiles_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Output side: ready runs broken by short or long stalls
  always @(posedge clk_i) begin
    if (ready_run > 0) begin
      out_ready_i <= 1'b1;
      ready_run--;
    end else if (stall_run > 0) begin
      out_ready_i <= 1'b0;
      stall_run--;
    end else begin
      ready_run = $urandom_range(40, 1);
      case ($urandom_range(9, 0))
        0, 1, 2: stall_run = 0;
        3:       stall_run = $urandom_range(30, 10);
        default: stall_run = $urandom_range(6, 1);
      endcase
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(15, 0))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255, 0));
    endcase
  endfunction

  // Transfer one pixel; bursts of random length with random gaps between
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      burst_left = $urandom_range(48, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold input idle until every expected tile is out, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tiles_pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                            input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] bh);
    cfg_write_i <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= fw;
    @(posedge clk_i);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= fh;
    @(posedge clk_i);
    cfg_index_i <= REG_BLOCK_WIDTH;
    cfg_data_i  <= bw;
    @(posedge clk_i);
    cfg_index_i <= REG_BLOCK_HEIGHT;
    cfg_data_i  <= bh;
    @(posedge clk_i);
    cfg_write_i <= 1'b0;
  endtask

  task automatic run_frames(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                            input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] bh,
                            input int n);
    drain();
    set_config(fw, fh, bw, bh);
    repeat (n) send_pixel(random_pixel());
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] fw, fh, bw, bh;
    int w_eff, h_eff, lim_w, lim_h, area, n, random_pixels;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: 640 x 480 with 8 x 8 tiles, nothing closes yet
    send_pixel(8'd255);
    send_pixel(8'd0);

    // Partial tiles on the right and bottom edges
    drain();
    set_config(12'd5, 12'd3, 12'd2, 12'd2);
    foreach (partial_frame_px[i]) send_pixel(partial_frame_px[i]);

    // Tile wider than the frame: no complete tile at all
    drain();
    set_config(12'd3, 12'd3, 12'd4, 12'd1);
    send_pixel(8'd255);
    send_pixel(8'd7);
    send_pixel(8'd0);

    // Zero registers saturate to 1: each pixel closes a frame of its own
    drain();
    set_config(12'd0, 12'd0, 12'd0, 12'd0);
    send_pixel(8'd0);
    send_pixel(8'd0);

    // All-ones registers saturate to a 2048 x 2048 frame with 16 x 16 tiles
    drain();
    set_config(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd128);

    // Long row, tall column (past the frame end), largest tiles
    run_frames(12'd160, 12'd2, 12'd1, 12'd1, 320);
    run_frames(12'd1, 12'd120, 12'd1, 12'd1, 122);
    run_frames(12'd32, 12'd16, 12'd16, 12'd16, 512);

    // Random shapes: mostly small frames, at most 100 pixels per run, some raw register values
    random_pixels = 0;
    while (random_pixels < 400) begin
      fw    = ($urandom_range(19, 0) == 0) ? CFG_DATA_W'($urandom_range(4095, 0))
                                           : CFG_DATA_W'($urandom_range(24, 1));
      fh    = ($urandom_range(19, 0) == 0) ? CFG_DATA_W'($urandom_range(4095, 0))
                                           : CFG_DATA_W'($urandom_range(24, 1));
      w_eff = (fw == 0) ? 1 : ((fw > MAX_WIDTH) ? MAX_WIDTH : fw);
      h_eff = (fh == 0) ? 1 : ((fh > ROWS_LIMIT) ? ROWS_LIMIT : fh);
      lim_w = (w_eff > MAX_TILE) ? MAX_TILE : w_eff;
      lim_h = (h_eff > MAX_TILE) ? MAX_TILE : h_eff;
      bw    = ($urandom_range(9, 0) == 0) ? CFG_DATA_W'($urandom_range(4095, 0))
                                          : CFG_DATA_W'($urandom_range(lim_w, 1));
      bh    = ($urandom_range(9, 0) == 0) ? CFG_DATA_W'($urandom_range(4095, 0))
                                          : CFG_DATA_W'($urandom_range(lim_h, 1));
      area  = w_eff * h_eff;
      if (area <= 300 && $urandom_range(3, 0) != 0) begin
        n = area * $urandom_range(2, 1);
      end else begin
        n = $urandom_range(200, 1);
      end
      if (n > 100) n = 100;
      run_frames(fw, fh, bw, bh, n);
      random_pixels += n;
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- block_max_pooling.f -----
design/bmp_pkg.sv
design/bmp_ram.sv
design/bmp_pos.sv
design/bmp_update.sv
design/block_max_pooling.sv
bench/bmp_checker.sv
bench/block_max_pooling_tb.sv
